@@ hw/rtl/a7pag_pkg.sv @@
// Shared types, constants and pass geometry for the Adam7 pixel address generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package a7pag_pkg;

  localparam int unsigned PIXEL_W         = 64;
  localparam int unsigned DEST_ROW_W      = 16;
  localparam int unsigned DEST_OFF_W      = 19;
  localparam int unsigned PASS_W          = 3;
  localparam int unsigned BPP_W           = 4;
  localparam int unsigned NUM_PASSES      = 7;
  localparam int unsigned MAX_PIXEL_BYTES = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned SHIFT_W         = 2;
  localparam int unsigned START_W         = 3;
  // Output data bus: pixel, row and byte offset, padded to whole bytes.
  localparam int unsigned TDATA_W         = ((PIXEL_W + DEST_ROW_W + DEST_OFF_W + 7) / 8) * 8;
  localparam int unsigned TDATA_PAD_W     = TDATA_W - PIXEL_W - DEST_ROW_W - DEST_OFF_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd2;

  typedef logic [PASS_W-1:0] pass_t;

  // Per-item control bits handed from the front to the back.
  typedef struct packed {
    pass_t pass;
    logic  last;
  } a7pag_tag_t;

  localparam int unsigned TAG_W = $bits(a7pag_tag_t);

  function automatic logic [START_W-1:0] pass_start_col(input pass_t p);
    logic [START_W-1:0] v;
    case (p)
      3'd1:    v = 3'd4;
      3'd3:    v = 3'd2;
      3'd5:    v = 3'd1;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [START_W-1:0] pass_start_row(input pass_t p);
    logic [START_W-1:0] v;
    case (p)
      3'd2:    v = 3'd4;
      3'd4:    v = 3'd2;
      3'd6:    v = 3'd1;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

  // Steps are powers of two; these give log2 of the column and row step.
  function automatic logic [SHIFT_W-1:0] pass_col_shift(input pass_t p);
    logic [SHIFT_W-1:0] v;
    case (p)
      3'd0, 3'd1: v = 2'd3;
      3'd2, 3'd3: v = 2'd2;
      3'd4, 3'd5: v = 2'd1;
      default:    v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [SHIFT_W-1:0] pass_row_shift(input pass_t p);
    logic [SHIFT_W-1:0] v;
    case (p)
      3'd0, 3'd1, 3'd2: v = 2'd3;
      3'd3, 3'd4:       v = 2'd2;
      default:          v = 2'd1;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/a7pag_queue.sv @@
// Two-entry queue that decouples the counter front from the address back.
// Depends on nothing but its WIDTH parameter.
`timescale 1ns / 1ps

module a7pag_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/a7pag_front.sv @@
// Front of the Adam7 address generator: configuration registers and the pass,
// row and column counters. Depends on a7pag_pkg.
`timescale 1ns / 1ps

module a7pag_front import a7pag_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [DIM_BITS-1:0]                   cfg_data_i,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [PIXEL_W-1:0]                    s_data_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output logic [PIXEL_W+2*DIM_BITS+TAG_W-1:0]   q_data_o,
  output logic [BPP_W-1:0]                      bpp_o
);

  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [BPP_W-1:0]    bpp_q, bpp_d;
  pass_t               pass_q, pass_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [DIM_BITS-1:0] col_q, col_d;

  logic                cfg_hit;
  logic                any_used;
  logic [7:0]          used;
  logic [DIM_BITS:0]   pw_ext, ph_ext;
  logic [DIM_BITS-1:0] pw, ph;
  logic                col_last, row_last;
  pass_t               nxt_pass;
  logic                nxt_found;
  a7pag_tag_t          tag;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && ((cfg_index_i == CFG_WIDTH) ||
                       (cfg_index_i == CFG_HEIGHT) || (cfg_index_i == CFG_BPP));

  // Pass 0 starts at the origin, so the image has pixels exactly when it has both dimensions.
  assign any_used  = (width_q != '0) && (height_q != '0);
  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i && any_used;
  assign bpp_o     = bpp_q;

  always_comb begin
    used = '0;
    for (int i = 0; i < NUM_PASSES; i++) begin
      used[i] = (width_q > DIM_BITS'(pass_start_col(PASS_W'(i)))) &&
                (height_q > DIM_BITS'(pass_start_row(PASS_W'(i))));
    end
  end

  // Pass size is ceil((size - start) / step); the step is a power of two.
  always_comb begin
    pw_ext = ({1'b0, width_q} + (DIM_BITS+1)'((4'd1 << pass_col_shift(pass_q)) - 4'd1 -
             {1'b0, pass_start_col(pass_q)})) >> pass_col_shift(pass_q);
    ph_ext = ({1'b0, height_q} + (DIM_BITS+1)'((4'd1 << pass_row_shift(pass_q)) - 4'd1 -
             {1'b0, pass_start_row(pass_q)})) >> pass_row_shift(pass_q);
    pw = DIM_BITS'(pw_ext);
    ph = DIM_BITS'(ph_ext);
  end

  assign col_last = (col_q == (pw - DIM_BITS'(1)));
  assign row_last = (row_q == (ph - DIM_BITS'(1)));

  // Lowest non-empty pass above the current one.
  always_comb begin
    nxt_pass  = '0;
    nxt_found = 1'b0;
    for (int i = NUM_PASSES - 1; i >= 0; i--) begin
      if (used[i] && (PASS_W'(i) > pass_q)) begin
        nxt_pass  = PASS_W'(i);
        nxt_found = 1'b1;
      end
    end
  end

  always_comb begin
    tag.pass = pass_q;
    tag.last = col_last && row_last && !nxt_found;
  end

  assign q_data_o = {tag, col_q, row_q, s_data_i};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    pass_d   = pass_q;
    row_d    = row_q;
    col_d    = col_q;
    if (cfg_hit) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        CFG_BPP:    bpp_d    = cfg_data_i[BPP_W-1:0];
        default:    ;
      endcase
      // Any register write restarts the image.
      pass_d = '0;
      row_d  = '0;
      col_d  = '0;
    end else if (q_push_o) begin
      if (!col_last) begin
        col_d = col_q + DIM_BITS'(1);
      end else begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + DIM_BITS'(1);
        end else begin
          row_d  = '0;
          pass_d = nxt_found ? nxt_pass : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(1);
      height_q <= DIM_BITS'(1);
      bpp_q    <= BPP_W'(1);
      pass_q   <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
      pass_q   <= pass_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

endmodule

@@ hw/rtl/a7pag_back.sv @@
// Back of the Adam7 address generator: destination row and byte offset math
// and the output register. Depends on a7pag_pkg.
`timescale 1ns / 1ps

module a7pag_back import a7pag_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  logic [PIXEL_W+2*DIM_BITS+TAG_W-1:0]   q_data_i,
  output logic                                  q_pop_o,
  input  logic [BPP_W-1:0]                      bpp_i,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [TDATA_W-1:0]                    m_data_o,
  output logic [PASS_W-1:0]                     m_user_o,
  output logic                                  m_last_o
);

  localparam int unsigned ITEM_W = PIXEL_W + 2 * DIM_BITS + TAG_W;
  localparam int unsigned PROD_W = DEST_OFF_W + BPP_W;

  logic [PIXEL_W-1:0]    pix;
  logic [DIM_BITS-1:0]   prow, pcol;
  a7pag_tag_t            tag;
  logic [DIM_BITS+2:0]   row_full, col_full;
  logic [DEST_OFF_W-1:0] col_trim;
  logic [BPP_W-1:0]      bpp_eff;
  logic [PROD_W-1:0]     prod;

  logic                  valid_q, valid_d;
  logic [PIXEL_W-1:0]    pix_q;
  logic [DEST_ROW_W-1:0] row_q;
  logic [DEST_OFF_W-1:0] off_q;
  pass_t                 pass_q;
  logic                  last_q;

  assign pix  = q_data_i[PIXEL_W-1:0];
  assign prow = q_data_i[PIXEL_W +: DIM_BITS];
  assign pcol = q_data_i[PIXEL_W+DIM_BITS +: DIM_BITS];
  assign tag  = a7pag_tag_t'(q_data_i[ITEM_W-1 -: TAG_W]);

  always_comb begin
    row_full = ({3'b000, prow} << pass_row_shift(tag.pass)) +
               (DIM_BITS+3)'(pass_start_row(tag.pass));
    col_full = ({3'b000, pcol} << pass_col_shift(tag.pass)) +
               (DIM_BITS+3)'(pass_start_col(tag.pass));
    col_trim = DEST_OFF_W'(col_full);
    if (bpp_i == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_i > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_i;
    end
    prod = PROD_W'(col_trim) * PROD_W'(bpp_eff);
  end

  // The output register refills in the same cycle that its content is taken.
  assign q_pop_o = q_valid_i && (!valid_q || m_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pix_q  <= pix;
      row_q  <= DEST_ROW_W'(row_full);
      off_q  <= DEST_OFF_W'(prod);
      pass_q <= tag.pass;
      last_q <= tag.last;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {{TDATA_PAD_W{1'b0}}, off_q, row_q, pix_q};
  assign m_user_o  = pass_q;
  assign m_last_o  = last_q;

endmodule

@@ hw/rtl/adam7_pixel_address_generator.sv @@
// Top level of the Adam7 pixel address generator: front counters, queue and
// address back end. Depends on a7pag_pkg, a7pag_front, a7pag_queue and a7pag_back.
`timescale 1ns / 1ps

// Takes the unfiltered pixels of an Adam7-interlaced image in pass order and returns
// each one with its destination row, its byte offset within that row (column times
// bytes per pixel, clamped to 1..8), its pass number on tuser and tlast on the final
// pixel of the image. The block sustains one pixel per cycle while the output
// takes results. A pixel is written into a two-entry queue at its input transfer,
// then goes through the address multiply into the output register, from which it
// leaves. While the output is held off, the queue and the output register take three
// pixels before the input stalls. Any register write restarts the image at pass 0;
// the user must see that registers are written only while no pixel is in flight;
// the block does not enforce this. While width or height is zero, pixels are taken
// and dropped without a result. After the last pixel the counters start the next image.
module adam7_pixel_address_generator import a7pag_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIM_BITS-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIXEL_W-1:0]    s_axis_tdata,   // [63:0] pixel_data
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [63:0] pixel_out, [79:64] dest_row,
                                                // [98:80] dest_byte_offset, rest zero
  output logic [PASS_W-1:0]     m_axis_tuser,   // [2:0] pass_number
  output logic                  m_axis_tlast    // last_pixel
);

  localparam int unsigned ITEM_W = PIXEL_W + 2 * DIM_BITS + TAG_W;

  logic              q_push, q_full, q_pop, q_valid;
  logic [ITEM_W-1:0] q_wdata, q_rdata;
  logic [BPP_W-1:0]  bpp;

  a7pag_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .bpp_o      (bpp)
  );

  a7pag_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  a7pag_back #(
    .DIM_BITS(DIM_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .bpp_i    (bpp),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_user_o (m_axis_tuser),
    .m_last_o (m_axis_tlast)
  );

  // The front never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("item pushed into full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("item popped from empty queue");

  // Results carry a real pass number and zero padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 3'd7) &&
                      (m_axis_tdata[TDATA_W-1:TDATA_W-TDATA_PAD_W] == '0))
    else $error("bad pass number or padding on result");

endmodule
